// File: sv/gdd_pkg.sv
// Shared types, constants and calendar helpers for the Gregorian date decrement core.
// Used by the controller, the datapath and the mod-400 unit.
package gdd_pkg;

  typedef enum logic [2:0] {
    KIND_DAYS           = 3'd0,
    KIND_WEEKS          = 3'd1,
    KIND_MONTHS         = 3'd2,
    KIND_YEARS_STEP     = 3'd3,
    KIND_YEARS_DIRECT   = 3'd4,
    KIND_DECADES_STEP   = 3'd5,
    KIND_DECADES_DIRECT = 3'd6
  } kind_e;

  localparam int unsigned NW = 19;  // remaining-units counter, holds 32767 * 10

  localparam logic [10:0] MOD_RECIP  = 11'd1311; // 2^15 / 25, rounded up
  localparam logic [8:0]  MOD_OFFSET = 9'd368;   // 32768 mod 400
  localparam logic [8:0]  MOD_FIX    = 9'd32;    // 400 - 368
  localparam logic [15:0] YEAR_MIN   = 16'h8000;
  localparam logic [8:0]  R_LAST     = 9'd399;
  localparam logic [8:0]  R_WRAP     = 9'd367;   // 32767 mod 400
  localparam logic [3:0]  MON_JAN    = 4'd1;
  localparam logic [3:0]  MON_FEB    = 4'd2;
  localparam logic [3:0]  MON_DEC    = 4'd12;
  localparam logic [4:0]  DAY_LEAP   = 5'd29;
  localparam logic [4:0]  DAY_FEB    = 5'd28;
  localparam logic [4:0]  DAY_LONG   = 5'd31;
  localparam logic [4:0]  DAY_SHORT  = 5'd30;

  typedef struct packed {
    logic load;
    logic prep;
    logic mod_start;
    logic run_step;
    logic fin;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic mod_done;
    logic run_last;
    logic is_run;
    logic is_skip;
  } status_t;

  // r is the year taken mod 400, in 0..399
  function automatic logic leap_from_mod(logic [8:0] r);
    logic century;
    century = (r == 9'd100) || (r == 9'd200) || (r == 9'd300);
    return (r[1:0] == 2'b00) && !century;
  endfunction

  function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
    logic [4:0] len;
    unique case (m)
      4'd2:                   len = leap ? DAY_LEAP : DAY_FEB;
      4'd4, 4'd6, 4'd9, 4'd11: len = DAY_SHORT;
      default:                len = DAY_LONG;
    endcase
    return len;
  endfunction

endpackage

// File: sv/gdd_if.sv
// Valid/ready channel interfaces for request and result words.
// Depends on nothing but plain logic types.
interface gdd_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [14:0]        count;
  logic [4:0]         in_day;
  logic [3:0]         in_month;
  logic signed [15:0] in_year;

  modport source (output valid, kind, count, in_day, in_month, in_year, input ready);
  modport sink   (input valid, kind, count, in_day, in_month, in_year, output ready);
endinterface

interface gdd_rsp_if;
  logic               valid;
  logic               ready;
  logic [4:0]         out_day;
  logic [3:0]         out_month;
  logic signed [15:0] out_year;

  modport source (output valid, out_day, out_month, out_year, input ready);
  modport sink   (input valid, out_day, out_month, out_year, output ready);
endinterface

// File: sv/gdd_mod400.sv
// Unit that reduces a 16-bit signed year mod 400 with a reciprocal multiply.
// Uses gdd_pkg constants.
module gdd_mod400 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] src_i,
  output logic        done_o,
  output logic [8:0]  rem_o
);

  logic [15:0] u_q, u_d;
  logic [22:0] prod_q, prod_d;
  logic [8:0]  rem_q, rem_d;
  logic        mul_q;
  logic        sub_q;
  logic        done_q;
  logic [7:0]  quot;
  logic [11:0] q25;
  logic [11:0] r25;
  logic [8:0]  adj;

  // bias to unsigned: u = y + 32768; hold until the next start
  assign u_d = start_i ? (src_i ^ gdd_pkg::YEAR_MIN) : u_q;

  // u mod 400 = ((u >> 4) mod 25) * 16 + (u mod 16)
  assign prod_d = {11'd0, u_q[15:4]} * {12'd0, gdd_pkg::MOD_RECIP};
  assign quot   = prod_q[22:15];
  assign q25    = ({4'd0, quot} << 4) + ({4'd0, quot} << 3) + {4'd0, quot};
  assign r25    = u_q[15:4] - q25;
  assign rem_d  = {r25[4:0], u_q[3:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q  <= 1'b0;
      sub_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      mul_q  <= start_i;
      sub_q  <= mul_q;
      done_q <= sub_q;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q    <= u_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
  end

  // remove the bias: (u - 32768) mod 400
  assign adj    = (rem_q >= gdd_pkg::MOD_OFFSET) ? (rem_q - gdd_pkg::MOD_OFFSET)
                                                 : (rem_q + gdd_pkg::MOD_FIX);
  assign rem_o  = adj;
  assign done_o = done_q;

endmodule

// File: sv/gdd_datapath.sv
// Date registers, month stepping and year arithmetic for the date decrement core.
// Depends on gdd_pkg and instantiates gdd_mod400.
module gdd_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gdd_pkg::cmd_t      cmd_i,
  output gdd_pkg::status_t   status_o,
  input  logic [2:0]         kind_i,
  input  logic [14:0]        count_i,
  input  logic [4:0]         in_day_i,
  input  logic [3:0]         in_month_i,
  input  logic signed [15:0] in_year_i,
  output logic [4:0]         out_day_o,
  output logic [3:0]         out_month_o,
  output logic signed [15:0] out_year_o
);

  logic [2:0]              kind_q;
  logic [gdd_pkg::NW-1:0]  n_q, n_d;
  logic [4:0]              d_q, d_d;
  logic [3:0]              m_q, m_d;
  logic [15:0]             y_q, y_d;
  logic [8:0]              r_q, r_d;
  logic [4:0]              od_q;
  logic [3:0]              om_q;
  logic [15:0]             oy_q;

  logic                    k_days, k_months, k_step, k_direct;
  logic [gdd_pkg::NW-1:0]  cnt_ext, n_load;
  logic [gdd_pkg::NW-1:0]  d_ext;
  logic [15:0]             y_sub;
  logic [15:0]             mod_src;
  logic                    mod_done;
  logic [8:0]              mod_rem;
  logic [3:0]              m_prev;
  logic [15:0]             y_prev;
  logic [8:0]              r_prev;
  logic [4:0]              len_prev;
  logic                    feb29;

  assign k_days   = (kind_q == gdd_pkg::KIND_DAYS) || (kind_q == gdd_pkg::KIND_WEEKS);
  assign k_months = (kind_q == gdd_pkg::KIND_MONTHS);
  assign k_step   = (kind_q == gdd_pkg::KIND_YEARS_STEP) ||
                    (kind_q == gdd_pkg::KIND_DECADES_STEP);
  assign k_direct = (kind_q == gdd_pkg::KIND_YEARS_DIRECT) ||
                    (kind_q == gdd_pkg::KIND_DECADES_DIRECT);

  assign cnt_ext = {{(gdd_pkg::NW-15){1'b0}}, count_i};
  always_comb begin
    unique case (kind_i)
      gdd_pkg::KIND_WEEKS:          n_load = (cnt_ext << 3) - cnt_ext;
      gdd_pkg::KIND_DECADES_STEP,
      gdd_pkg::KIND_DECADES_DIRECT: n_load = (cnt_ext << 3) + (cnt_ext << 1);
      default:                      n_load = cnt_ext;
    endcase
  end

  assign d_ext = {{(gdd_pkg::NW-5){1'b0}}, d_q};
  assign y_sub = y_q - n_q[15:0];

  always_comb begin
    if (k_direct)    mod_src = y_sub;
    else if (k_step) mod_src = y_q - 16'd1;  // leap test of the year just before start
    else             mod_src = y_q;
  end

  gdd_mod400 u_mod400 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mod_start),
    .src_i   (mod_src),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  // one month back, tracking the year mod 400 alongside the year
  always_comb begin
    if (m_q == gdd_pkg::MON_JAN) begin
      m_prev = gdd_pkg::MON_DEC;
      y_prev = y_q - 16'd1;
      if (y_q == gdd_pkg::YEAR_MIN) r_prev = gdd_pkg::R_WRAP;
      else if (r_q == 9'd0)         r_prev = gdd_pkg::R_LAST;
      else                          r_prev = r_q - 9'd1;
    end else begin
      m_prev = m_q - 4'd1;
      y_prev = y_q;
      r_prev = r_q;
    end
    len_prev = gdd_pkg::month_len(m_prev, gdd_pkg::leap_from_mod(r_prev));
  end

  assign feb29 = (m_q == gdd_pkg::MON_FEB) && (d_q == gdd_pkg::DAY_LEAP);

  always_comb begin
    n_d = n_q;
    d_d = d_q;
    m_d = m_q;
    y_d = y_q;
    r_d = r_q;
    if (cmd_i.load) begin
      d_d = (in_day_i == 5'd0) ? 5'd1 : in_day_i;
      if (in_month_i == 4'd0)                 m_d = gdd_pkg::MON_JAN;
      else if (in_month_i > gdd_pkg::MON_DEC) m_d = gdd_pkg::MON_DEC;
      else                                    m_d = in_month_i;
      y_d = in_year_i;
      n_d = n_load;
    end else if (cmd_i.prep) begin
      if (k_direct) y_d = y_sub;
    end else if (cmd_i.run_step) begin
      if (k_days) begin
        if (n_q < d_ext) begin
          d_d = d_q - n_q[4:0];
          n_d = '0;
        end else begin
          n_d = n_q - d_ext;
          m_d = m_prev;
          y_d = y_prev;
          r_d = r_prev;
          d_d = len_prev;
        end
      end else if (n_q != '0) begin
        n_d = n_q - {{(gdd_pkg::NW-1){1'b0}}, 1'b1};
        m_d = m_prev;
        y_d = y_prev;
        r_d = r_prev;
        if (d_q > len_prev) d_d = len_prev;
      end
    end else if (cmd_i.fin) begin
      if (k_step) begin
        y_d = y_sub;
        // two consecutive years are never both leap
        if (feb29 && (n_q != '0) &&
            ((n_q > {{(gdd_pkg::NW-1){1'b0}}, 1'b1}) || !gdd_pkg::leap_from_mod(r_q)))
          d_d = gdd_pkg::DAY_FEB;
      end else if (k_direct) begin
        if (feb29 && !gdd_pkg::leap_from_mod(r_q)) d_d = gdd_pkg::DAY_FEB;
      end
    end
    if (mod_done) r_d = mod_rem;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) kind_q <= kind_i;
    n_q <= n_d;
    d_q <= d_d;
    m_q <= m_d;
    y_q <= y_d;
    r_q <= r_d;
    if (cmd_i.out_load) begin
      od_q <= d_q;
      om_q <= m_q;
      oy_q <= y_q;
    end
  end

  assign status_o.mod_done = mod_done;
  assign status_o.run_last = k_days ? (n_q < d_ext)
                                    : (n_q <= {{(gdd_pkg::NW-1){1'b0}}, 1'b1});
  assign status_o.is_run   = k_days || k_months;
  assign status_o.is_skip  = (kind_q > gdd_pkg::KIND_DECADES_DIRECT);

  assign out_day_o   = od_q;
  assign out_month_o = om_q;
  assign out_year_o  = oy_q;

endmodule

// File: sv/gdd_ctrl.sv
// Sequencer for the date decrement core: load, year reduction, month loop or year fix-up, result word.
// Depends on gdd_pkg command and status structs.
module gdd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  gdd_pkg::status_t status_i,
  output gdd_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MOD,
    S_RUN,
    S_FIN,
    S_OUT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = (state_q == S_IDLE) && in_valid_i;
    cmd_o.prep      = (state_q == S_PREP);
    cmd_o.mod_start = (state_q == S_PREP) && !status_i.is_skip;
    cmd_o.run_step  = (state_q == S_RUN);
    cmd_o.fin       = (state_q == S_FIN);
    cmd_o.out_load  = (state_q == S_OUT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load)   out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_PREP;
        S_PREP: state_q <= status_i.is_skip ? S_OUT : S_MOD;
        S_MOD: begin
          if (status_i.mod_done) state_q <= status_i.is_run ? S_RUN : S_FIN;
        end
        S_RUN: if (status_i.run_last) state_q <= S_OUT;
        S_FIN: state_q <= S_OUT;
        S_OUT: if (out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: sv/gregorian_date_decrement_core.sv
// Gregorian date decrement core: takes a date, a count and a kind and returns the
// earlier date. Request words arrive on req_i, result words leave on rsp_o, both
// valid/ready; a word moves on a clock edge with valid and ready high.
// One request is worked at a time. After acceptance the core biases the year and
// reduces it mod 400 with a reciprocal multiply and, with the remainder in place, runs:
//   year and decade kinds: the fix-up state;
//   day and week kinds: the month loop, back a month at a time to the month reached;
//   month kinds: the month loop, back one month per count, at least one step.
// The result is then written to the output register; the unused kind skips the
// reduction, the loop and the fix-up. The next request is taken only after the
// result is written to the output register.
// The result sits in an output register; while the receiver stalls it holds, and a
// following result waits in the core until that register frees up.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops any
// pending result; no memory needs clearing.
// Depends on gdd_pkg, gdd_if, gdd_ctrl, gdd_datapath and gdd_mod400.
module gregorian_date_decrement_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  gdd_req_if.sink    req_i,
  gdd_rsp_if.source  rsp_o
);

  gdd_pkg::cmd_t    cmd;
  gdd_pkg::status_t status;

  gdd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  gdd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .kind_i      (req_i.kind),
    .count_i     (req_i.count),
    .in_day_i    (req_i.in_day),
    .in_month_i  (req_i.in_month),
    .in_year_i   (req_i.in_year),
    .out_day_o   (rsp_o.out_day),
    .out_month_o (rsp_o.out_month),
    .out_year_o  (rsp_o.out_year)
  );

endmodule

// File: tb/tb_gregorian_date_decrement_core.sv
// Self-checking bench for gregorian_date_decrement_core: a directed table and random
// requests, checked word by word against tabled dates or an in-bench calendar predictor.
// Depends on gdd_pkg, gdd_if and the core itself.
`timescale 1ns / 100ps

module tb_gregorian_date_decrement_core;

  // no operation is assigned to code 7; the core passes the date through, with day and month clamped
  localparam logic [2:0] KIND_NONE   = 3'd7;
  localparam int         CYCLE_LIMIT = 2_000_000;
  localparam int         N_RANDOM    = 1625;
  localparam int         N_DIRECTED  = 25;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
  } date_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [14:0] count;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic        typed;
    date_t       want;
  } date_row_t;

  localparam date_row_t DIR_TAB [N_DIRECTED] = '{
    '{gdd_pkg::KIND_DAYS, 15'd0, 5'd15, 4'd6, 16'd2000, 1'b1, '{5'd15, 4'd6, 16'd2000}},
    '{gdd_pkg::KIND_DAYS, 15'd1, 5'd1, 4'd1, 16'd2000, 1'b1, '{5'd31, 4'd12, 16'd1999}},
    '{gdd_pkg::KIND_DAYS, 15'd1, 5'd1, 4'd3, 16'd2000, 1'b1, '{5'd29, 4'd2, 16'd2000}},
    '{gdd_pkg::KIND_DAYS, 15'd1, 5'd1, 4'd3, 16'd1900, 1'b1, '{5'd28, 4'd2, 16'd1900}},
    '{gdd_pkg::KIND_DAYS, 15'd1, 5'd1, 4'd3, 16'd2024, 1'b1, '{5'd29, 4'd2, 16'd2024}},
    '{gdd_pkg::KIND_DAYS, 15'd1, 5'd0, 4'd0, 16'd2001, 1'b1, '{5'd31, 4'd12, 16'd2000}},
    '{gdd_pkg::KIND_DAYS, 15'd1, 5'd1, 4'd1, 16'h8000, 1'b1, '{5'd31, 4'd12, 16'd32767}},
    '{gdd_pkg::KIND_DAYS, 15'd5, 5'd31, 4'd15, 16'd5, 1'b1, '{5'd26, 4'd12, 16'd5}},
    '{gdd_pkg::KIND_DAYS, 15'd32767, 5'd31, 4'd12, 16'd32767, 1'b0, '0},
    '{gdd_pkg::KIND_WEEKS, 15'd1, 5'd8, 4'd3, 16'd2023, 1'b1, '{5'd1, 4'd3, 16'd2023}},
    '{gdd_pkg::KIND_WEEKS, 15'd32767, 5'd7, 4'd6, 16'd2000, 1'b0, '0},
    '{gdd_pkg::KIND_MONTHS, 15'd1, 5'd31, 4'd3, 16'd2023, 1'b1, '{5'd28, 4'd2, 16'd2023}},
    '{gdd_pkg::KIND_MONTHS, 15'd1, 5'd31, 4'd3, 16'd2024, 1'b1, '{5'd29, 4'd2, 16'd2024}},
    '{gdd_pkg::KIND_MONTHS, 15'd32767, 5'd31, 4'd12, 16'd0, 1'b0, '0},
    '{gdd_pkg::KIND_MONTHS, 15'd1, 5'd15, 4'd1, 16'h8000, 1'b1,
      '{5'd15, 4'd12, 16'd32767}},
    '{gdd_pkg::KIND_YEARS_STEP, 15'd1, 5'd29, 4'd2, 16'd2024, 1'b1,
      '{5'd28, 4'd2, 16'd2023}},
    '{gdd_pkg::KIND_YEARS_STEP, 15'd4, 5'd29, 4'd2, 16'd2024, 1'b1,
      '{5'd28, 4'd2, 16'd2020}},
    '{gdd_pkg::KIND_YEARS_STEP, 15'd0, 5'd29, 4'd2, 16'd2023, 1'b1,
      '{5'd29, 4'd2, 16'd2023}},
    '{gdd_pkg::KIND_YEARS_STEP, 15'd1, 5'd29, 4'd2, 16'd2025, 1'b1,
      '{5'd29, 4'd2, 16'd2024}},
    '{gdd_pkg::KIND_YEARS_DIRECT, 15'd4, 5'd29, 4'd2, 16'd2024, 1'b1,
      '{5'd29, 4'd2, 16'd2020}},
    '{gdd_pkg::KIND_YEARS_DIRECT, 15'd0, 5'd29, 4'd2, 16'd2023, 1'b1,
      '{5'd28, 4'd2, 16'd2023}},
    '{gdd_pkg::KIND_YEARS_DIRECT, 15'd32767, 5'd1, 4'd1, 16'h8000, 1'b1,
      '{5'd1, 4'd1, 16'd1}},
    '{gdd_pkg::KIND_DECADES_STEP, 15'd32767, 5'd29, 4'd2, 16'd32767, 1'b0, '0},
    '{gdd_pkg::KIND_DECADES_DIRECT, 15'd1, 5'd29, 4'd2, 16'd2000, 1'b1,
      '{5'd28, 4'd2, 16'd1990}},
    '{KIND_NONE, 15'd100, 5'd0, 4'd14, 16'd1234, 1'b1, '{5'd1, 4'd12, 16'd1234}}
  };

  logic clk_i;
  logic rst_ni;

  gdd_req_if req_if ();
  gdd_rsp_if rsp_if ();

  gregorian_date_decrement_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  date_t due_dates_q [$];
  int    words_sent;
  int    words_checked = 0;
  int    mismatch_cnt  = 0;
  int    cycle_cnt     = 0;
  int    burst_left;
  int    kind_seen [8];

  // ---------------------------------------------------------------- predictor
  function automatic bit leap_year(logic [15:0] y);
    int v;
    v = 32'($signed(y));
    return ((v % 4 == 0) && (v % 100 != 0)) || (v % 400 == 0);
  endfunction

  function automatic int unsigned days_in(logic [15:0] y, int unsigned m);
    int unsigned len;
    case (m)
      2:             len = leap_year(y) ? 29 : 28;
      4, 6, 9, 11:   len = 30;
      default:       len = 31;
    endcase
    return len;
  endfunction

  function automatic date_t earlier_date(logic [2:0] kind, logic [14:0] count,
                                        logic [4:0] day, logic [3:0] month,
                                        logic [15:0] year);
    int unsigned d;
    int unsigned m;
    int unsigned n;
    logic [15:0] y;
    logic [15:0] start;
    date_t res;
    d = 32'(day);
    m = 32'(month);
    y = year;
    n = 32'(count);
    if (d == 0) d = 1;
    if (m == 0) m = 1;
    if (m > 12) m = 12;
    case (kind)
      gdd_pkg::KIND_DAYS, gdd_pkg::KIND_WEEKS: begin
        if (kind == gdd_pkg::KIND_WEEKS) n = n * 7;
        // walk back a month at a time; the day counts down from its given value
        while (n > 0) begin
          if (n < d) begin
            d = d - n;
            n = 0;
          end else begin
            n = n - d;
            if (m == 1) begin
              m = 12;
              y = y - 16'd1;
            end else begin
              m = m - 1;
            end
            d = days_in(y, m);
          end
        end
      end
      gdd_pkg::KIND_MONTHS: begin
        for (int i = 0; i < n; i++) begin
          if (m == 1) begin
            m = 12;
            y = y - 16'd1;
          end else begin
            m = m - 1;
          end
          if (d > days_in(y, m)) d = days_in(y, m);
        end
      end
      gdd_pkg::KIND_YEARS_STEP, gdd_pkg::KIND_DECADES_STEP: begin
        if (kind == gdd_pkg::KIND_DECADES_STEP) n = n * 10;
        start = y;
        y = y - n[15:0];
        // two leap years never follow each other, so only a one-year step can keep 29
        if (m == 2 && d == 29 && n > 0 && (n >= 2 || !leap_year(start - 16'd1))) d = 28;
      end
      gdd_pkg::KIND_YEARS_DIRECT, gdd_pkg::KIND_DECADES_DIRECT: begin
        if (kind == gdd_pkg::KIND_DECADES_DIRECT) n = n * 10;
        y = y - n[15:0];
        if (m == 2 && d == 29 && !leap_year(y)) d = 28;
      end
      default: ;
    endcase
    res.day   = d[4:0];
    res.month = m[3:0];
    res.year  = y;
    return res;
  endfunction

  // ---------------------------------------------------------------- clock, limit
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d words still due", cycle_cnt, due_dates_q.size());
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------- request side
  task automatic put_word(input logic [2:0] kind, input logic [14:0] count,
                          input logic [4:0] day, input logic [3:0] month,
                          input logic [15:0] year, input logic typed, input date_t want);
    int gap;
    req_if.kind     <= kind;
    req_if.count    <= count;
    req_if.in_day   <= day;
    req_if.in_month <= month;
    req_if.in_year  <= year;
    req_if.valid    <= 1'b1;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    due_dates_q.push_back(typed ? want : earlier_date(kind, count, day, month, year));
    words_sent++;
    kind_seen[kind]++;
    // bursts of back-to-back words, then at times a random pause
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(24, 1);
      gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(12, 1);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // ---------------------------------------------------------------- result side
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    bit pressure_done;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    pressure_done = 1'b0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      // one long hold while requests keep coming, so the core backs up into its input
      if (!pressure_done && words_sent >= 300) begin
        pressure_done = 1'b1;
        hold_left = 600;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(3);
        mode_left = $urandom_range(200, 20);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        case (mode)
          0:       rsp_if.ready <= 1'b1;
          1:       rsp_if.ready <= 1'($urandom_range(1));
          2:       rsp_if.ready <= ($urandom_range(3) == 0);
          default: rsp_if.ready <= (cycle_cnt % 8 < 5);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    date_t exp_d;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (due_dates_q.size() == 0) begin
        $display("%0t unexpected word: got %0d-%0d-%0d", $time,
                 $signed(rsp_if.out_year), rsp_if.out_month, rsp_if.out_day);
        mismatch_cnt++;
      end else begin
        exp_d = due_dates_q.pop_front();
        words_checked++;
        if (rsp_if.out_day !== exp_d.day) begin
          $display("%0t out_day: expected %0d, got %0d", $time, exp_d.day, rsp_if.out_day);
          mismatch_cnt++;
        end
        if (rsp_if.out_month !== exp_d.month) begin
          $display("%0t out_month: expected %0d, got %0d", $time, exp_d.month,
                   rsp_if.out_month);
          mismatch_cnt++;
        end
        if (rsp_if.out_year !== exp_d.year) begin
          $display("%0t out_year: expected %0d, got %0d", $time, $signed(exp_d.year),
                   $signed(rsp_if.out_year));
          mismatch_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- main sequence
  initial begin
    logic [2:0]  kind;
    logic [14:0] count;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    int          r;
    words_sent    = 0;
    burst_left    = 0;
    foreach (kind_seen[k]) kind_seen[k] = 0;
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.kind     = gdd_pkg::KIND_DAYS;
    req_if.count    = '0;
    req_if.in_day   = 5'd1;
    req_if.in_month = gdd_pkg::MON_JAN;
    req_if.in_year  = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIR_TAB[i])
      put_word(DIR_TAB[i].kind, DIR_TAB[i].count, DIR_TAB[i].day, DIR_TAB[i].month,
               DIR_TAB[i].year, DIR_TAB[i].typed, DIR_TAB[i].want);

    for (int i = 0; i < N_RANDOM; i++) begin
      kind = ($urandom_range(99) < 5) ? KIND_NONE : 3'($urandom_range(6));
      case ($urandom_range(4))
        0:       year = 16'($urandom);
        1:       year = 16'(1500 + $urandom_range(1000));
        2:       year = gdd_pkg::YEAR_MIN + 16'($urandom_range(20));
        3:       year = 16'h7FFF - 16'($urandom_range(20));
        default: year = 16'($urandom_range(40)) - 16'd20;
      endcase
      if ($urandom_range(9) == 0) begin
        // day and month fields that may be out of range
        day   = 5'($urandom_range(31));
        month = 4'($urandom_range(15));
      end else begin
        month = 4'($urandom_range(12, 1));
        r = $urandom_range(3);
        if (r == 0) day = 5'(days_in(year, 32'(month)));
        else day = 5'($urandom_range(days_in(year, 32'(month)), 1));
        if (kind >= gdd_pkg::KIND_YEARS_STEP && $urandom_range(2) == 0) begin
          month = gdd_pkg::MON_FEB;
          day   = gdd_pkg::DAY_LEAP;
        end
      end
      // keep day, week and month loops short apart from a few full-range counts
      r = $urandom_range(99);
      case (kind)
        gdd_pkg::KIND_DAYS:   count = (r < 3) ? 15'($urandom) : 15'($urandom_range(70));
        gdd_pkg::KIND_WEEKS:  count = (r < 2) ? 15'($urandom) : 15'($urandom_range(12));
        gdd_pkg::KIND_MONTHS: begin
          if (r < 1) count = 15'($urandom);
          else if (r < 4) count = 15'($urandom_range(2000));
          else count = 15'($urandom_range(30));
        end
        default:     count = (r < 60) ? 15'($urandom) : 15'($urandom_range(5));
      endcase
      put_word(kind, count, day, month, year, 1'b0, '0);
    end
    req_if.valid <= 1'b0;

    wait (due_dates_q.size() == 0);
    repeat (50) @(posedge clk_i);
    $display("covered %0d requests (%0d from the directed table), %0d result words compared",
             words_sent, N_DIRECTED, words_checked);
    $display("kinds: days %0d weeks %0d months %0d yrs %0d/%0d decades %0d/%0d unused %0d",
             kind_seen[gdd_pkg::KIND_DAYS], kind_seen[gdd_pkg::KIND_WEEKS],
             kind_seen[gdd_pkg::KIND_MONTHS],
             kind_seen[gdd_pkg::KIND_YEARS_STEP], kind_seen[gdd_pkg::KIND_YEARS_DIRECT],
             kind_seen[gdd_pkg::KIND_DECADES_STEP], kind_seen[gdd_pkg::KIND_DECADES_DIRECT],
             kind_seen[KIND_NONE]);
    if (mismatch_cnt == 0 && due_dates_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/gdd_pkg.sv
sv/gdd_if.sv
sv/gdd_mod400.sv
sv/gdd_datapath.sv
sv/gdd_ctrl.sv
sv/gregorian_date_decrement_core.sv
tb/tb_gregorian_date_decrement_core.sv
